[sv/cltstore_pkg.sv]
// Types and codes for the consensus log term store.
// No dependencies.
package cltstore_pkg;

	typedef enum logic [2:0] {
		CMD_APPEND   = 3'd0,
		CMD_LOOKUP   = 3'd1,
		CMD_COMPACT  = 3'd2,
		CMD_SNAP     = 3'd3,
		CMD_APPLY    = 3'd4
	} cmd_t;

	typedef enum logic [2:0] {
		ST_OK          = 3'd0,
		ST_COMPACTED   = 3'd1,
		ST_BEYOND_END  = 3'd2,
		ST_BEYOND_LAST = 3'd3,
		ST_OLDER       = 3'd4,
		ST_GAP         = 3'd5,
		ST_FULL        = 3'd6
	} status_t;

	typedef struct packed {
		logic [2:0]  cmd;
		logic [63:0] entry_index;
		logic [63:0] entry_term;
	} in_word_t;

	typedef struct packed {
		logic [2:0]  status;
		logic [63:0] term_out;
		logic [63:0] first_idx;
		logic [63:0] last_idx;
	} out_word_t;

endpackage

[sv/consensus_log_term_store_core.sv]
// Top level of the consensus log term store.
// Depends on cltstore_pkg, cltstore_fifo, cltstore_back.
//
// Term table of a replicated log kept as a ring of LOG_DEPTH terms behind a
// compaction base. Each command taken into the input queue gives exactly one
// result word. A two-entry input queue decouples push from the executor; the
// executor steps through latch, synchronous ring read and execute for each
// command, the indices are posted the cycle after, and the word enters a
// two-entry result queue the cycle after that. The executor takes one command
// at a time; a full result queue or a pending result push stalls it.
module consensus_log_term_store_core #(
	parameter int LOG_DEPTH = 256
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    push,
	output logic                    full,
	input  cltstore_pkg::in_word_t  in_word,
	output logic                    empty,
	input  logic                    pop,
	output cltstore_pkg::out_word_t out_word
);
	import cltstore_pkg::*;

	in_word_t  q_word;
	logic      q_empty, take;
	out_word_t res_word;
	logic      res_valid, res_full, post_q, rq_full;
	typedef enum logic [1:0] {P_IDLE, P_WAIT, P_PUSH} pst_t;
	pst_t pst_q;

	cltstore_fifo #(.WIDTH($bits(in_word_t))) u_inq (
		.clk, .arst_n, .wr(push), .wdata(in_word), .full,
		.rd(take && !q_empty), .rdata(q_word), .empty(q_empty)
	);

	cltstore_back #(.LOG_DEPTH(LOG_DEPTH)) u_back (
		.clk, .arst_n, .cmd_valid(!q_empty), .cmd_word(q_word), .cmd_take(take),
		.res_valid, .res_word, .res_full
	);

	// hold the executor in its done state until the result queue has room and no
	// push is pending; push the result via P_WAIT and P_PUSH, once indices are posted
	assign res_full = rq_full || pst_q != P_IDLE;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) pst_q <= P_IDLE;
		else case (pst_q)
			P_IDLE: if (res_valid && !res_full) pst_q <= P_WAIT;
			P_WAIT: pst_q <= P_PUSH;
			P_PUSH: pst_q <= P_IDLE;
			default: pst_q <= P_IDLE;
		endcase
	end
	assign post_q = pst_q == P_PUSH;

	cltstore_fifo #(.WIDTH($bits(out_word_t))) u_outq (
		.clk, .arst_n, .wr(post_q), .wdata(res_word), .full(rq_full),
		.rd(pop), .rdata(out_word), .empty
	);

	a_push_room: assert property (@(posedge clk) disable iff (!arst_n)
		post_q |-> !rq_full) else $error("result push into full queue");
	a_status: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> out_word.status <= ST_FULL) else $error("bad status");
	a_term: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && out_word.status != ST_OK) |-> out_word.term_out == 64'd0)
		else $error("term on failed step");
endmodule

[sv/cltstore_fifo.sv]
// Small word queue between front and back, and the result queue.
// Depends on nothing; width is a parameter.
module cltstore_fifo #(
	parameter int WIDTH = 8
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             wr,
	input  logic [WIDTH-1:0] wdata,
	output logic             full,
	input  logic             rd,
	output logic [WIDTH-1:0] rdata,
	output logic             empty
);
	logic [WIDTH-1:0] mem_q [2];
	logic             wp_q, rp_q;
	logic [1:0]       cnt_q;

	assign full  = cnt_q == 2'd2;
	assign empty = cnt_q == 2'd0;
	assign rdata = mem_q[rp_q];

	always_ff @(posedge clk) begin
		if (wr && !full) mem_q[wp_q] <= wdata;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= 1'b0;
			rp_q <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (wr && !full) wp_q <= !wp_q;
			if (rd && !empty) rp_q <= !rp_q;
			cnt_q <= cnt_q + 2'(wr && !full) - 2'(rd && !empty);
		end
	end
endmodule

[sv/cltstore_back.sv]
// Back end: holds log state and the term ring, executes one command.
// Depends on cltstore_pkg.
module cltstore_back #(
	parameter int LOG_DEPTH = 256
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cmd_valid,
	input  cltstore_pkg::in_word_t cmd_word,
	output logic                   cmd_take,
	output logic                   res_valid,
	output cltstore_pkg::out_word_t res_word,
	input  logic                   res_full
);
	import cltstore_pkg::*;

	localparam int AW = (LOG_DEPTH > 1) ? $clog2(LOG_DEPTH) : 1;
	localparam int CW = $clog2(LOG_DEPTH + 1);

	typedef enum logic [1:0] {S_IDLE, S_READ, S_DONE} state_t;

	logic [63:0]   ring_q [LOG_DEPTH];
	logic [63:0]   rdata_q;
	state_t        state_q;
	in_word_t      w_q;
	logic [AW-1:0] head_q;
	logic [CW-1:0] count_q;
	logic [63:0]   base_idx_q, base_term_q, snap_idx_q, snap_term_q;
	logic [63:0]   off, last;
	logic [AW-1:0] slot, head_nx;
	logic          in_log;
	logic          ap_ok;
	logic          ring_wr;
	logic [63:0]   term_d;
	logic [2:0]    st_d, st_q;
	logic [63:0]   tout_d, tout_q, first_q, last_q;

	// ring position modulo LOG_DEPTH; the sum is below twice the depth
	function automatic logic [AW-1:0] ring_slot(logic [AW:0] s);
		if (s >= (AW+1)'(LOG_DEPTH)) return AW'(s - (AW+1)'(LOG_DEPTH));
		return AW'(s);
	endfunction

	assign last    = base_idx_q + 64'(count_q);
	assign off     = w_q.entry_index - base_idx_q;
	assign in_log  = off <= 64'(count_q);
	assign slot    = ring_slot({1'b0, head_q} + (AW+1)'(off - 64'd1));
	assign head_nx = ring_slot({1'b0, head_q} + (AW+1)'(off));
	assign cmd_take = state_q == S_IDLE;
	assign res_valid = state_q == S_DONE;
	assign res_word  = '{status: st_q, term_out: tout_q, first_idx: first_q, last_idx: last_q};
	assign term_d = (off == 64'd0) ? base_term_q : rdata_q;

	assign ap_ok = w_q.cmd == CMD_APPEND && w_q.entry_index > base_idx_q &&
		(in_log || (off == 64'(count_q) + 64'd1 && count_q < CW'(LOG_DEPTH)));
	assign ring_wr = state_q == S_READ && ap_ok;

	always_comb begin
		st_d = ST_OK;
		tout_d = '0;
		case (w_q.cmd)
			CMD_APPEND: begin
				if (!ap_ok && w_q.entry_index > base_idx_q)
					st_d = (off == 64'(count_q) + 64'd1) ? ST_FULL : ST_GAP;
			end
			CMD_LOOKUP: begin
				if (w_q.entry_index < base_idx_q) st_d = ST_COMPACTED;
				else if (!in_log) st_d = ST_BEYOND_END;
				else tout_d = term_d;
			end
			CMD_COMPACT: begin
				if (w_q.entry_index <= base_idx_q) st_d = ST_COMPACTED;
				else if (w_q.entry_index > last) st_d = ST_BEYOND_LAST;
			end
			CMD_SNAP: begin
				if (w_q.entry_index <= snap_idx_q) st_d = ST_OLDER;
				else if (w_q.entry_index > last) st_d = ST_BEYOND_LAST;
				else if (w_q.entry_index < base_idx_q) st_d = ST_COMPACTED;
			end
			CMD_APPLY: begin
				if (snap_idx_q >= w_q.entry_index) st_d = ST_OLDER;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (ring_wr) ring_q[slot] <= w_q.entry_term;
		rdata_q <= ring_q[slot];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			w_q <= '0;
			st_q <= ST_OK;
			tout_q <= '0;
			head_q <= '0;
			count_q <= '0;
			base_idx_q <= '0;
			base_term_q <= '0;
			snap_idx_q <= '0;
			snap_term_q <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (cmd_valid) begin
						w_q <= cmd_word;
						state_q <= S_READ;
					end
				end
				S_READ: begin
					state_q <= S_DONE;
				end
				S_DONE: begin
					if (!res_full) begin
						state_q <= S_IDLE;
						st_q <= st_d;
						tout_q <= tout_d;
						case (w_q.cmd)
							CMD_APPEND: begin
								if (ap_ok) count_q <= CW'(off);
							end
							CMD_COMPACT: begin
								if (st_d == ST_OK) begin
									base_term_q <= term_d;
									base_idx_q <= w_q.entry_index;
									head_q <= head_nx;
									count_q <= count_q - CW'(off);
								end
							end
							CMD_SNAP: begin
								if (st_d == ST_OK) begin
									snap_term_q <= term_d;
									snap_idx_q <= w_q.entry_index;
								end
							end
							CMD_APPLY: begin
								if (st_d == ST_OK) begin
									snap_idx_q <= w_q.entry_index;
									snap_term_q <= w_q.entry_term;
									base_idx_q <= w_q.entry_index;
									base_term_q <= w_q.entry_term;
									count_q <= '0;
									head_q <= '0;
								end
							end
							default: ;
						endcase
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// first/last reported from state after the step; registered via post_q in the cycle after it
	logic post_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) post_q <= 1'b0;
		else post_q <= state_q == S_DONE && !res_full;
	end
	always_ff @(posedge clk) begin
		if (post_q) begin
			first_q <= base_idx_q + 64'd1;
			last_q  <= last;
		end
	end
endmodule
